// ----- design/pei_pkg.sv -----
package pei_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = DiffW + CoordW;   // (p - a) * n
  localparam int unsigned DistW  = ProdW + 2;        // sum of three products
  localparam int unsigned MagW   = DistW - 1;        // |da|
  localparam int unsigned SumW   = DistW;            // |da| + |db|
  localparam int unsigned FracW  = 16;               // t
  localparam int unsigned OffW   = DiffW + FracW + 1; // (b - a) * t
  localparam int unsigned NumDivCells = FracW;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_PLANE_X  = 3'd0,
    REG_PLANE_Y  = 3'd1,
    REG_PLANE_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } reg_idx_e;

  localparam logic [CoordW-1:0] NormalZReset = 16'd256;

  typedef struct packed {
    logic [2:0][CoordW-1:0] a;
    logic [2:0][CoordW-1:0] b;
  } pts_t;

  typedef struct packed {
    pts_t            pts;
    logic            hit;
    logic [SumW-1:0] s;  // divisor
    logic [SumW-1:0] r;  // partial remainder, always below s on a hit
    logic [FracW-1:0] q;
  } div_t;

endpackage

// ----- design/pei_if.sv -----
interface pei_seg_if;
  logic        valid;
  logic        ready;
  logic [15:0] end_a_x;
  logic [15:0] end_a_y;
  logic [15:0] end_a_z;
  logic [15:0] end_b_x;
  logic [15:0] end_b_y;
  logic [15:0] end_b_z;

  modport source (output valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
                  input ready);
  modport sink   (input valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
                  output ready);
endinterface

interface pei_cross_if;
  logic        valid;
  logic        ready;
  logic [15:0] cross_x;
  logic [15:0] cross_y;
  logic [15:0] cross_z;

  modport source (output valid, cross_x, cross_y, cross_z, input ready);
  modport sink   (input valid, cross_x, cross_y, cross_z, output ready);
endinterface

// ----- design/pei_div_cell.sv -----
module pei_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  pei_pkg::div_t  data_i,
  output logic           ready_o,
  output logic           valid_o,
  output pei_pkg::div_t  data_o,
  input  logic           ready_i
);

  logic          v_q;
  pei_pkg::div_t data_q;
  pei_pkg::div_t data_d;
  logic [pei_pkg::SumW:0] r2;
  logic [pei_pkg::SumW:0] diff;
  logic                   ge;

  // one restoring step: one quotient bit per cell
  always_comb begin
    r2     = {data_i.r, 1'b0};
    diff   = r2 - {1'b0, data_i.s};
    ge     = (r2 >= {1'b0, data_i.s});
    data_d = data_i;
    data_d.r = ge ? diff[pei_pkg::SumW-1:0] : r2[pei_pkg::SumW-1:0];
    data_d.q = {data_i.q[pei_pkg::FracW-2:0], ge};
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

endmodule

// ----- design/plane_edge_intersection.sv -----
// Channel  | Dir | Payload                          | Beat when
// seg_i    | in  | end_a_x/y/z, end_b_x/y/z (Q8.8)  | valid && ready
// cross_o  | out | cross_x/y/z (Q8.8)               | valid && ready
// cfg      | in  | cfg_addr_i, cfg_wdata_i          | cfg_we_i
//
// One edge per cycle unless cross_o stalls; 4 front stages, 16 divider
// cells, product stage, output register. The divider is a row of cells,
// one quotient bit each. Edges without a strict sign change are dropped at
// the output register. Each stage advances when it is empty or its
// successor advances, so bubbles collapse under stall. Reset clears all
// valids and loads the plane registers with point 0 and normal (0, 0, 1.0).
module plane_edge_intersection (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pei_pkg::RegIdxW-1:0] cfg_addr_i,
  input  logic [pei_pkg::CoordW-1:0]  cfg_wdata_i,
  pei_seg_if.sink                     seg_i,
  pei_cross_if.source                 cross_o
);

  localparam int unsigned W  = pei_pkg::CoordW;
  localparam int unsigned NC = pei_pkg::NumDivCells;

  logic [2:0][W-1:0] pnt_q, nrm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnt_q <= '0;
      nrm_q <= {pei_pkg::NormalZReset, {(2*W){1'b0}}};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pei_pkg::REG_PLANE_X:  pnt_q[0] <= cfg_wdata_i;
        pei_pkg::REG_PLANE_Y:  pnt_q[1] <= cfg_wdata_i;
        pei_pkg::REG_PLANE_Z:  pnt_q[2] <= cfg_wdata_i;
        pei_pkg::REG_NORMAL_X: nrm_q[0] <= cfg_wdata_i;
        pei_pkg::REG_NORMAL_Y: nrm_q[1] <= cfg_wdata_i;
        pei_pkg::REG_NORMAL_Z: nrm_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ready chain
  logic rdy0, rdy1, rdy2, rdy3, rdy_c0, rdy_p, rdy_o;
  logic v0_q, v1_q, v2_q, v3_q, vp_q, vo_q;

  // stage 0: input capture
  pei_pkg::pts_t s0_q;
  // stage 1: six products
  pei_pkg::pts_t s1_pts_q;
  logic signed [2:0][pei_pkg::ProdW-1:0] s1_pa_q, s1_pb_q;
  // stage 2: distances
  pei_pkg::pts_t s2_pts_q;
  logic signed [pei_pkg::DistW-1:0] da_q, db_q;
  // stage 3: divider operands
  pei_pkg::div_t s3_q, s3_d;

  assign seg_i.ready = rdy0;
  assign rdy0 = !v0_q || rdy1;
  assign rdy1 = !v1_q || rdy2;
  assign rdy2 = !v2_q || rdy3;
  assign rdy3 = !v3_q || rdy_c0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= seg_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  logic signed [2:0][pei_pkg::DiffW-1:0] dfa, dfb;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dfa[k] = $signed({s0_q.a[k][W-1], s0_q.a[k]}) - $signed({pnt_q[k][W-1], pnt_q[k]});
      dfb[k] = $signed({s0_q.b[k][W-1], s0_q.b[k]}) - $signed({pnt_q[k][W-1], pnt_q[k]});
    end
  end

  // elements of a packed array are unsigned, so sign is restored explicitly
  logic signed [pei_pkg::DistW-1:0] da_d, db_d;
  always_comb begin
    da_d = '0;
    db_d = '0;
    for (int k = 0; k < 3; k++) begin
      da_d = da_d + pei_pkg::DistW'($signed(s1_pa_q[k]));
      db_d = db_d + pei_pkg::DistW'($signed(s1_pb_q[k]));
    end
  end

  logic [pei_pkg::MagW-1:0] ma, mb;
  always_comb begin
    ma = da_q[pei_pkg::DistW-1] ? pei_pkg::MagW'(-da_q) : pei_pkg::MagW'(da_q);
    mb = db_q[pei_pkg::DistW-1] ? pei_pkg::MagW'(-db_q) : pei_pkg::MagW'(db_q);
    s3_d.pts = s2_pts_q;
    s3_d.hit = (da_q > 0 && db_q < 0) || (da_q < 0 && db_q > 0);
    s3_d.s   = pei_pkg::SumW'(ma) + pei_pkg::SumW'(mb);
    s3_d.r   = pei_pkg::SumW'(ma);
    s3_d.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && seg_i.valid) begin
      s0_q.a <= {seg_i.end_a_z, seg_i.end_a_y, seg_i.end_a_x};
      s0_q.b <= {seg_i.end_b_z, seg_i.end_b_y, seg_i.end_b_x};
    end
    if (rdy1 && v0_q) begin
      s1_pts_q <= s0_q;
      for (int k = 0; k < 3; k++) begin
        s1_pa_q[k] <= $signed(dfa[k]) * $signed(nrm_q[k]);
        s1_pb_q[k] <= $signed(dfb[k]) * $signed(nrm_q[k]);
      end
    end
    if (rdy2 && v1_q) begin
      s2_pts_q <= s1_pts_q;
      da_q     <= da_d;
      db_q     <= db_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  // divider row
  logic          cv  [NC+1];
  logic          crdy[NC+1];
  pei_pkg::div_t cd  [NC+1];

  assign cv[0]   = v3_q;
  assign cd[0]   = s3_q;
  assign rdy_c0  = crdy[0];
  assign crdy[NC] = rdy_p;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    pei_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .data_i  (cd[i]),
      .ready_o (crdy[i]),
      .valid_o (cv[i+1]),
      .data_o  (cd[i+1]),
      .ready_i (crdy[i+1])
    );
  end

  // product stage: (b - a) * t
  logic                                 p_hit_q;
  logic [2:0][W-1:0]                    p_a_q;
  logic signed [2:0][pei_pkg::OffW-1:0] p_off_q;
  logic signed [2:0][pei_pkg::DiffW-1:0] dba;
  pei_pkg::div_t                        cl;

  assign cl = cd[NC];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dba[k] = $signed({cl.pts.b[k][W-1], cl.pts.b[k]}) -
               $signed({cl.pts.a[k][W-1], cl.pts.a[k]});
    end
  end

  assign rdy_p = !vp_q || rdy_o;
  assign rdy_o = !vo_q || cross_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_p) vp_q <= cv[NC];
      if (rdy_o) vo_q <= vp_q && p_hit_q;
    end
  end

  logic [2:0][W-1:0] cross_d, cross_q;
  logic signed [2:0][pei_pkg::OffW-1:0] sh;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sh[k]      = $signed(p_off_q[k]) >>> pei_pkg::FracW;  // floor
      cross_d[k] = p_a_q[k] + sh[k][W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && cv[NC]) begin
      p_hit_q <= cl.hit;
      p_a_q   <= cl.pts.a;
      for (int k = 0; k < 3; k++) begin
        p_off_q[k] <= pei_pkg::OffW'($signed(dba[k])) * $signed({1'b0, cl.q});
      end
    end
    if (rdy_o && vp_q && p_hit_q) begin
      cross_q <= cross_d;
    end
  end

  assign cross_o.valid   = vo_q;
  assign cross_o.cross_x = cross_q[0];
  assign cross_o.cross_y = cross_q[1];
  assign cross_o.cross_z = cross_q[2];

  // a hit always has a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_q.hit |-> s3_q.s != '0)
    else $error("hit with zero divisor");

  // remainder stays below the divisor at the end of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[NC] && cl.hit |-> cl.r < cl.s)
    else $error("divider remainder out of range");

  // a stalled product stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp_q && !rdy_o |=> vp_q)
    else $error("item lost in product stage");

endmodule
